// ===== src/point_to_line_vector_defines.svh =====
// ----------------------------------------------------------------------------
// Point to line vector assertion macros
// Shared property forms for the block's checkers.
// ----------------------------------------------------------------------------
`ifndef POINT_TO_LINE_VECTOR_DEFINES_SVH
`define POINT_TO_LINE_VECTOR_DEFINES_SVH

// implication checked outside reset
`define PTLV_ASSERT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// condition in the cycle after a reset cycle
`define PTLV_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

// ===== src/ptlv_pkg.sv =====
// ----------------------------------------------------------------------------
// Point to line vector package
// Shared constants and stage control type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptlv_pkg;

  localparam int TOL_W       = 23;
  localparam int T_CLAMP_EXP = 62;
  localparam int T_MAG_W     = 63;
  localparam int T_SPLIT     = 32;

  typedef struct packed {
    logic vld;
    logic dir_ok;
  } ptlv_ctl_t;

endpackage

`default_nettype wire

// ===== src/point_to_line_vector.sv =====
// Throughput: one item per cycle while busy is low; the divider spends one pipeline stage per quotient bit.
// busy is high for one cycle after reset and low otherwise; the receiver cannot stall.
// Reset clears all stage valid bits and the tolerance register to zero.
// ----------------------------------------------------------------------------
// Point to line vector
// Vector from a point to its perpendicular foot on a 3-D line, pipelined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module point_to_line_vector import ptlv_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_start_z,
  input  logic signed [COORD_WIDTH-1:0] in_dir_x,
  input  logic signed [COORD_WIDTH-1:0] in_dir_y,
  input  logic signed [COORD_WIDTH-1:0] in_dir_z,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_z,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [TOL_W-1:0]              cfg_zero_tolerance,
  output logic                          out_strobe,
  output logic signed [COORD_WIDTH-1:0] out_to_line_x,
  output logic signed [COORD_WIDTH-1:0] out_to_line_y,
  output logic signed [COORD_WIDTH-1:0] out_to_line_z,
  output logic                          out_valid_res
);

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 1;
  localparam int DNW = 2 * CW;
  localparam int QW  = 2 * CW + 3 + T_FRAC_BITS;
  localparam int SW  = 1 + 3 * CW + 3 * DW;

  logic busy_r;
  logic [TOL_W-1:0] tol_r;
  ptlv_ctl_t f_ctl, q_ctl;
  logic f_neg, q_neg;
  logic [QW-1:0] f_dvd, q_quot;
  logic [DNW-1:0] f_den;
  logic [2:0][CW-1:0] f_dir, q_dir, vec;
  logic [2:0][DW-1:0] f_d, q_d;
  logic [SW-1:0] f_side, q_side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      tol_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        tol_r <= cfg_zero_tolerance;
      end
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  ptlv_front #(.CW(CW), .TF(T_FRAC_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (start && !busy_r),
    .tol    (tol_r),
    .st     ({in_start_z, in_start_y, in_start_x}),
    .dir    ({in_dir_z, in_dir_y, in_dir_x}),
    .pt     ({in_point_z, in_point_y, in_point_x}),
    .ctl_o  (f_ctl),
    .neg_o  (f_neg),
    .dvd_o  (f_dvd),
    .den_o  (f_den),
    .dir_o  (f_dir),
    .d_o    (f_d)
  );

  assign f_side = {f_neg, f_dir, f_d};

  ptlv_div #(.QW(QW), .DNW(DNW), .SW(SW)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (f_ctl),
    .side_i (f_side),
    .dvd_i  (f_dvd),
    .den_i  (f_den),
    .ctl_o  (q_ctl),
    .side_o (q_side),
    .quot_o (q_quot)
  );

  assign {q_neg, q_dir, q_d} = q_side;

  ptlv_back #(.CW(CW), .TF(T_FRAC_BITS), .QW(QW)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (q_ctl),
    .quot_i   (q_quot),
    .neg_i    (q_neg),
    .dir_i    (q_dir),
    .d_i      (q_d),
    .strobe_o (out_strobe),
    .vec_o    (vec),
    .valid_o  (out_valid_res)
  );

  assign out_to_line_x = vec[0];
  assign out_to_line_y = vec[1];
  assign out_to_line_z = vec[2];

endmodule

`default_nettype wire

// ===== src/ptlv_front.sv =====
// ----------------------------------------------------------------------------
// Point to line vector front end
// Difference, dot products, sums and dividend forming in four stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptlv_front import ptlv_pkg::*; #(
  parameter int CW = 24,
  parameter int TF = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [TOL_W-1:0]              tol,
  input  logic [2:0][CW-1:0]            st,
  input  logic [2:0][CW-1:0]            dir,
  input  logic [2:0][CW-1:0]            pt,
  output ptlv_ctl_t                     ctl_o,
  output logic                          neg_o,
  output logic [2*CW+3+TF-1:0]          dvd_o,
  output logic [2*CW-1:0]               den_o,
  output logic [2:0][CW-1:0]            dir_o,
  output logic [2:0][CW:0]              d_o
);

  localparam int DW  = CW + 1;
  localparam int PW  = DW + CW;
  localparam int NW  = PW + 2;
  localparam int DNW = 2 * CW;
  localparam int QW  = NW + TF;
  localparam int MW  = (CW > TOL_W) ? CW : TOL_W;

  ptlv_ctl_t ctl1_r, ctl1_nxt, ctl2_r, ctl3_r, ctl4_r;
  logic [2:0][DW-1:0] d1_r, d1_nxt, d2_r, d3_r, d4_r;
  logic [2:0][CW-1:0] dir1_r, dir2_r, dir3_r, dir4_r;
  logic [2:0][PW-1:0] num2_r, num2_nxt;
  logic [2:0][DNW-1:0] sq2_r, sq2_nxt;
  logic [NW-1:0] num3_r, num3_nxt;
  logic [DNW-1:0] den3_r, den3_nxt, den4_r;
  logic neg4_r;
  logic [NW-1:0] mag4;
  logic [QW-1:0] dvd4_r;

  always_comb begin
    logic [CW-1:0] mag;
    logic ok;
    ok = 1'b0;
    for (int i = 0; i < 3; i++) begin
      d1_nxt[i] = {pt[i][CW-1], pt[i]} - {st[i][CW-1], st[i]};
      mag = dir[i][CW-1] ? (~dir[i] + CW'(1)) : dir[i];
      if (MW'(mag) > MW'(tol)) begin
        ok = 1'b1;
      end
    end
    ctl1_nxt.vld    = in_vld;
    ctl1_nxt.dir_ok = ok;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num2_nxt[i] = PW'($signed(d1_r[i]) * $signed(dir1_r[i]));
      sq2_nxt[i]  = DNW'($signed(dir1_r[i]) * $signed(dir1_r[i]));
    end
  end

  always_comb begin
    num3_nxt = NW'($signed(num2_r[0])) + NW'($signed(num2_r[1]))
             + NW'($signed(num2_r[2]));
    den3_nxt = sq2_r[0] + sq2_r[1] + sq2_r[2];
  end

  assign mag4 = num3_r[NW-1] ? (~num3_r + NW'(1)) : num3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else begin
      ctl1_r <= ctl1_nxt;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_r   <= d1_nxt;
    dir1_r <= dir;
    d2_r   <= d1_r;
    dir2_r <= dir1_r;
    num2_r <= num2_nxt;
    sq2_r  <= sq2_nxt;
    d3_r   <= d2_r;
    dir3_r <= dir2_r;
    num3_r <= num3_nxt;
    den3_r <= den3_nxt;
    d4_r   <= d3_r;
    dir4_r <= dir3_r;
    neg4_r <= num3_r[NW-1];
    dvd4_r <= {mag4, {TF{1'b0}}};
    den4_r <= den3_r;
  end

  assign ctl_o = ctl4_r;
  assign neg_o = neg4_r;
  assign dvd_o = dvd4_r;
  assign den_o = den4_r;
  assign dir_o = dir4_r;
  assign d_o   = d4_r;

endmodule

`default_nettype wire

// ===== src/ptlv_div.sv =====
// ----------------------------------------------------------------------------
// Point to line vector divider
// Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptlv_div import ptlv_pkg::*; #(
  parameter int QW  = 67,
  parameter int DNW = 48,
  parameter int SW  = 148
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ptlv_ctl_t        ctl_i,
  input  logic [SW-1:0]    side_i,
  input  logic [QW-1:0]    dvd_i,
  input  logic [DNW-1:0]   den_i,
  output ptlv_ctl_t        ctl_o,
  output logic [SW-1:0]    side_o,
  output logic [QW-1:0]    quot_o
);

  ptlv_ctl_t        ctl_r  [QW];
  logic [SW-1:0]    side_r [QW];
  logic [QW-1:0]    dvd_r  [QW];
  logic [QW-1:0]    quot_r [QW];
  logic [DNW-1:0]   den_r  [QW];
  logic [DNW-1:0]   rem_r  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stg
    ptlv_ctl_t      ctl_p;
    logic [SW-1:0]  side_p;
    logic [QW-1:0]  dvd_p, quot_p;
    logic [DNW-1:0] den_p, rem_p, rem_nxt;
    logic [DNW:0]   rem_sh;
    logic           ge;

    if (k == 0) begin : g_first
      assign ctl_p  = ctl_i;
      assign side_p = side_i;
      assign dvd_p  = dvd_i;
      assign quot_p = '0;
      assign den_p  = den_i;
      assign rem_p  = '0;
    end else begin : g_next
      assign ctl_p  = ctl_r[k-1];
      assign side_p = side_r[k-1];
      assign dvd_p  = dvd_r[k-1];
      assign quot_p = quot_r[k-1];
      assign den_p  = den_r[k-1];
      assign rem_p  = rem_r[k-1];
    end

    assign rem_sh  = {rem_p, dvd_p[QW-1]};
    assign ge      = rem_sh >= {1'b0, den_p};
    assign rem_nxt = ge ? DNW'(rem_sh - {1'b0, den_p}) : rem_sh[DNW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else begin
        ctl_r[k] <= ctl_p;
      end
    end

    always_ff @(posedge clk) begin
      side_r[k] <= side_p;
      dvd_r[k]  <= {dvd_p[QW-2:0], 1'b0};
      quot_r[k] <= {quot_p[QW-2:0], ge};
      den_r[k]  <= den_p;
      rem_r[k]  <= rem_nxt;
    end
  end

  assign ctl_o  = ctl_r[QW-1];
  assign side_o = side_r[QW-1];
  assign quot_o = quot_r[QW-1];

endmodule

`default_nettype wire

// ===== src/ptlv_back.sv =====
// ----------------------------------------------------------------------------
// Point to line vector back end
// Clamp t, scale the direction, round, subtract and saturate in five stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptlv_back import ptlv_pkg::*; #(
  parameter int CW = 24,
  parameter int TF = 16,
  parameter int QW = 67
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ptlv_ctl_t           ctl_i,
  input  logic [QW-1:0]       quot_i,
  input  logic                neg_i,
  input  logic [2:0][CW-1:0]  dir_i,
  input  logic [2:0][CW:0]    d_i,
  output logic                strobe_o,
  output logic [2:0][CW-1:0]  vec_o,
  output logic                valid_o
);

  localparam int DW  = CW + 1;
  localparam int QXW = (QW > 64) ? QW : 64;
  localparam int PXW = 64 + CW + TF;
  localparam int LW  = 64;
  localparam int RW  = LW + 2;
  localparam int PLW = T_SPLIT + CW;
  localparam int PHW = T_MAG_W - T_SPLIT + CW;

  ptlv_ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r;
  logic [2:0][DW-1:0] d1_r, d2_r, d3_r, d4_r;
  logic [2:0][CW-1:0] dir1_r;
  logic neg1_r;
  logic [T_MAG_W-1:0] tm1_r, tm1_nxt;
  logic [2:0][PLW-1:0] pl2_r, pl2_nxt;
  logic [2:0][PHW-1:0] ph2_r, ph2_nxt;
  logic [2:0] sgn2_r, sgn2_nxt, sgn3_r;
  logic [2:0][PXW-1:0] mag3_r, mag3_nxt, p4_r, p4_nxt;
  logic [2:0][CW-1:0] vec5_r, vec5_nxt;
  logic valid5_r;

  always_comb begin
    logic [QXW-1:0] qx;
    qx = QXW'(quot_i);
    if (qx > (QXW'(1) << T_CLAMP_EXP)) begin
      tm1_nxt = T_MAG_W'(1) << T_CLAMP_EXP;
    end else begin
      tm1_nxt = qx[T_MAG_W-1:0];
    end
  end

  always_comb begin
    logic [CW-1:0] md;
    for (int i = 0; i < 3; i++) begin
      md = dir1_r[i][CW-1] ? (~dir1_r[i] + CW'(1)) : dir1_r[i];
      pl2_nxt[i]  = PLW'(tm1_r[T_SPLIT-1:0]) * PLW'(md);
      ph2_nxt[i]  = PHW'(tm1_r[T_MAG_W-1:T_SPLIT]) * PHW'(md);
      sgn2_nxt[i] = neg1_r ^ dir1_r[i][CW-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag3_nxt[i] = (PXW'(ph2_r[i]) << T_SPLIT) + PXW'(pl2_r[i]);
      if (sgn3_r[i]) begin
        p4_nxt[i] = ~mag3_r[i] + ((PXW'(1) << (TF - 1)) + PXW'(1));
      end else begin
        p4_nxt[i] = mag3_r[i] + (PXW'(1) << (TF - 1));
      end
    end
  end

  always_comb begin
    logic [LW-1:0] lo;
    logic [RW-1:0] r;
    logic [RW-1:0] hi_lim, lo_lim;
    hi_lim = (RW'(1) << (CW - 1)) - RW'(1);
    lo_lim = ~hi_lim;
    for (int i = 0; i < 3; i++) begin
      lo = p4_r[i][TF+LW-1:TF];
      r  = {{(RW-LW){lo[LW-1]}}, lo} - {{(RW-DW){d4_r[i][DW-1]}}, d4_r[i]};
      if (!ctl4_r.dir_ok) begin
        vec5_nxt[i] = '0;
      end else if ($signed(r) > $signed(hi_lim)) begin
        vec5_nxt[i] = hi_lim[CW-1:0];
      end else if ($signed(r) < $signed(lo_lim)) begin
        vec5_nxt[i] = lo_lim[CW-1:0];
      end else begin
        vec5_nxt[i] = r[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
    end else begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
    end
  end

  always_ff @(posedge clk) begin
    tm1_r    <= tm1_nxt;
    neg1_r   <= neg_i;
    dir1_r   <= dir_i;
    d1_r     <= d_i;
    pl2_r    <= pl2_nxt;
    ph2_r    <= ph2_nxt;
    sgn2_r   <= sgn2_nxt;
    d2_r     <= d1_r;
    mag3_r   <= mag3_nxt;
    sgn3_r   <= sgn2_r;
    d3_r     <= d2_r;
    p4_r     <= p4_nxt;
    d4_r     <= d3_r;
    vec5_r   <= vec5_nxt;
    valid5_r <= ctl4_r.dir_ok;
  end

  assign strobe_o = ctl5_r.vld;
  assign vec_o    = vec5_r;
  assign valid_o  = valid5_r;

endmodule

`default_nettype wire

// ===== src/ptlv_checker.sv =====
// ----------------------------------------------------------------------------
// Point to line vector checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "point_to_line_vector_defines.svh"

module ptlv_checker #(
  parameter int COORD_WIDTH = 24
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   busy,
  input logic                   out_strobe,
  input logic                   out_valid_res,
  input logic [COORD_WIDTH-1:0] out_to_line_x,
  input logic [COORD_WIDTH-1:0] out_to_line_y,
  input logic [COORD_WIDTH-1:0] out_to_line_z
);

  `PTLV_ASSERT(a_zero_dir_vec, out_strobe && !out_valid_res, (out_to_line_x == '0) && (out_to_line_y == '0) && (out_to_line_z == '0), "invalid item with nonzero vector")
  `PTLV_ASSERT_RST(a_busy_after_rst, busy, "busy low after reset")
  `PTLV_ASSERT_RST(a_no_strobe_after_rst, !out_strobe, "item delivered right after reset")

endmodule

bind point_to_line_vector ptlv_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ptlv_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .busy          (busy),
  .out_strobe    (out_strobe),
  .out_valid_res (out_valid_res),
  .out_to_line_x (out_to_line_x),
  .out_to_line_y (out_to_line_y),
  .out_to_line_z (out_to_line_z)
);

`default_nettype wire
